// File: sv/lp2sc_pkg.sv
// Shared types and constants for the length-prefix to start-code converter.
package lp2sc_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEN_W       = 25;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned HEAD_BYTES  = 4;

	// Zero byte and last byte of a start code 00 00 00 01
	localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
	localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;

	typedef enum logic [1:0] {
		MODE_UNDECIDED,
		MODE_PASS,
		MODE_PREFIXED,
		MODE_PREPEND
	} conv_mode_t;

	// One queued job for the back end: optional start code, then up to four bytes.
	// No start code and no bytes means a bare end marker.
	typedef struct packed {
		logic                         start_code;
		logic [2:0]                   n_bytes;
		logic [HEAD_BYTES-1:0][7:0]   bytes;
		logic                         frame_end;
	} cmd_t;

endpackage

// File: sv/lp2sc_front.sv
// Front end: tracks frame state per input byte and issues output jobs.
module lp2sc_front import lp2sc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 16777216
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic [LEN_W-1:0]      frame_length,
	input  logic                  frame_start,
	output logic                  push,
	output cmd_t                  cmd
);

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FRAME_BYTES);

	logic [LEN_W-1:0]   bytes_seen_q;
	conv_mode_t         mode_q;
	logic [LEN_W-1:0]   nal_left_q;
	logic [23:0]        prefix_acc_q;
	logic [1:0]         prefix_cnt_q;
	logic               drop_q;
	logic [7:0]         head_q [HEAD_BYTES];

	logic [LEN_W-1:0]   seen, len;
	conv_mode_t         mode;
	logic [LEN_W-1:0]   nal_left;
	logic [23:0]        prefix_acc;
	logic [1:0]         prefix_cnt;
	logic               drop;
	logic               last;
	logic [3:0][7:0]    hc;
	logic [2:0]         held;
	logic               decide_now;
	logic [31:0]        word0;
	logic [31:0]        full_prefix;
	logic               sc4, sc3, pref_ok;

	logic [LEN_W-1:0]   seen_n, nal_left_n;
	conv_mode_t         mode_n;
	logic [23:0]        prefix_acc_n;
	logic [1:0]         prefix_cnt_n;
	logic               drop_n;

	// Frame start wipes the running state before this byte is used
	always_comb begin
		seen       = frame_start ? '0 : bytes_seen_q;
		mode       = frame_start ? MODE_UNDECIDED : mode_q;
		nal_left   = frame_start ? '0 : nal_left_q;
		prefix_acc = frame_start ? '0 : prefix_acc_q;
		prefix_cnt = frame_start ? '0 : prefix_cnt_q;
		drop       = frame_start ? 1'b0 : drop_q;
		len        = (frame_length == '0) ? LEN_W'(1) : frame_length;
		if (32'(len) > 32'(MAX_FRAME_BYTES)) begin
			len = MaxLen;
		end
	end

	// Held bytes with the current byte merged in, and the mode decision
	always_comb begin
		for (int i = 0; i < HEAD_BYTES; i++) begin
			hc[i] = (seen[1:0] == 2'(i)) ? data_byte : head_q[i];
		end
		last       = ({1'b0, seen} + 26'd1) >= {1'b0, len};
		held       = {1'b0, seen[1:0]} + 3'd1;
		decide_now = (seen[1:0] == 2'd3) || last;
		word0      = {hc[0], hc[1], hc[2], hc[3]};
		full_prefix = {prefix_acc, data_byte};
		sc4 = (len >= LEN_W'(4)) && (held == 3'd4) && (hc[0] == SC_ZERO_BYTE) &&
			(hc[1] == SC_ZERO_BYTE) && (hc[2] == SC_ZERO_BYTE) && (hc[3] == SC_LAST_BYTE);
		sc3 = (len >= LEN_W'(3)) && (held >= 3'd3) && (hc[0] == SC_ZERO_BYTE) &&
			(hc[1] == SC_ZERO_BYTE) && (hc[2] == SC_LAST_BYTE);
		pref_ok = (len > LEN_W'(4)) && (held == 3'd4) && (word0 != '0) &&
			(({1'b0, word0} + 33'd4) <= {8'b0, len});
	end

	// Next state and job contents
	always_comb begin
		seen_n       = seen + LEN_W'(1);
		mode_n       = mode;
		nal_left_n   = nal_left;
		prefix_acc_n = prefix_acc;
		prefix_cnt_n = prefix_cnt;
		drop_n       = drop;
		cmd.start_code = 1'b0;
		cmd.n_bytes    = 3'd0;
		cmd.bytes      = {HEAD_BYTES{data_byte}};
		cmd.frame_end  = last;
		unique case (mode)
			MODE_UNDECIDED: begin
				if (decide_now) begin
					cmd.bytes   = hc;
					cmd.n_bytes = held;
					if (sc4 || sc3) begin
						mode_n = MODE_PASS;
					end else if (pref_ok) begin
						mode_n         = MODE_PREFIXED;
						nal_left_n     = word0[LEN_W-1:0];
						cmd.start_code = 1'b1;
						cmd.n_bytes    = 3'd0;
					end else begin
						mode_n         = MODE_PREPEND;
						cmd.start_code = 1'b1;
					end
				end
			end
			MODE_PREFIXED: begin
				if (!drop) begin
					if (nal_left != '0) begin
						cmd.n_bytes = 3'd1;
						nal_left_n  = nal_left - LEN_W'(1);
					end else if (prefix_cnt == 2'd3) begin
						prefix_cnt_n = '0;
						prefix_acc_n = '0;
						if ((full_prefix == '0) || (({9'b0, seen} + 34'd1 +
							{2'b0, full_prefix}) > {9'b0, len})) begin
							drop_n = 1'b1;
						end else begin
							nal_left_n     = full_prefix[LEN_W-1:0];
							cmd.start_code = 1'b1;
						end
					end else begin
						prefix_acc_n = {prefix_acc[15:0], data_byte};
						prefix_cnt_n = prefix_cnt + 2'd1;
					end
				end
			end
			MODE_PASS, MODE_PREPEND: begin
				cmd.n_bytes = 3'd1;
			end
			default: begin
				mode_n = MODE_UNDECIDED;
			end
		endcase
		// End of frame returns to idle
		if (last) begin
			seen_n       = '0;
			mode_n       = MODE_UNDECIDED;
			nal_left_n   = '0;
			prefix_acc_n = '0;
			prefix_cnt_n = '0;
			drop_n       = 1'b0;
		end
	end

	assign push = accept && (cmd.start_code || (cmd.n_bytes != 3'd0) || last);

	// Frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			mode_q       <= MODE_UNDECIDED;
			nal_left_q   <= '0;
			prefix_acc_q <= '0;
			prefix_cnt_q <= '0;
			drop_q       <= 1'b0;
		end else if (accept) begin
			bytes_seen_q <= seen_n;
			mode_q       <= mode_n;
			nal_left_q   <= nal_left_n;
			prefix_acc_q <= prefix_acc_n;
			prefix_cnt_q <= prefix_cnt_n;
			drop_q       <= drop_n;
		end
	end

	// Held head bytes, written only before the decision
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_UNDECIDED) && (seen[LEN_W-1:2] == '0)) begin
			head_q[seen[1:0]] <= data_byte;
		end
	end

	a_drop_only_prefixed: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (mode_q == MODE_PREFIXED))
		else $error("drop flag set outside length-prefixed mode");

	a_decided_after_head: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_UNDECIDED) |-> (bytes_seen_q >= LEN_W'(4)))
		else $error("mode decided before four bytes were seen");

	a_prefix_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(prefix_cnt_q != 2'd0) |-> (nal_left_q == '0) && (mode_q == MODE_PREFIXED))
		else $error("prefix gathering while payload still pending");

endmodule

// File: sv/lp2sc_cmd_fifo.sv
// Small job queue between the front and back ends.
module lp2sc_cmd_fifo import lp2sc_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

	cmd_t            slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == DepthCnt);
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Job storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue popped while empty");

endmodule

// File: sv/lp2sc_back.sv
// Back end: expands each job into bytes in the output register, one per cycle unless stalled.
module lp2sc_back import lp2sc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	logic [2:0]        pos_q;
	logic [3:0]        total;
	logic              done;
	logic              advance;
	logic              has_data;
	logic [BYTE_W-1:0] res_byte;

	// Result count of the head job and the byte at the current position
	always_comb begin
		has_data = head.start_code || (head.n_bytes != 3'd0);
		if (head.start_code) begin
			total = 4'd4 + {1'b0, head.n_bytes};
		end else if (head.n_bytes == 3'd0) begin
			total = 4'd1;
		end else begin
			total = {1'b0, head.n_bytes};
		end
		done = ({1'b0, pos_q} + 4'd1) == total;
		priority if (!has_data) begin
			res_byte = SC_ZERO_BYTE;
		end else if (head.start_code && !pos_q[2]) begin
			res_byte = (pos_q[1:0] == 2'd3) ? SC_LAST_BYTE : SC_ZERO_BYTE;
		end else begin
			res_byte = head.bytes[pos_q[1:0]];
		end
	end

	assign advance = head_valid && (!m_tvalid || m_tready);
	assign pop     = advance && done;

	// Position within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= done ? '0 : pos_q + 3'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= res_byte;
			m_tuser <= has_data;
			m_tlast <= head.frame_end && done;
		end
	end

	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, pos_q} < total))
		else $error("result position beyond job length");

	a_pos_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (pos_q == '0))
		else $error("result position not cleared with no job pending");

endmodule

// File: sv/h264_length_prefix_to_start_code.sv
// The first result of an input byte reaches the master side through the job queue and the
//   output register; later results follow one per cycle while the output does not stall.
// Throughput: one input byte per cycle while the queue has room, one result per cycle unless
//   the output stalls; a byte's k results (start code, head bytes, up to 8) go out in turn.
// The job queue of QUEUE_DEPTH entries lets the input side keep running during such bursts.
// Reset: asynchronous, clears all frame state and the queue; the first byte opens a frame.
module h264_length_prefix_to_start_code import lp2sc_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 16777216,
	parameter int unsigned QUEUE_DEPTH     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte, [32:8] frame_length
	input  logic [0:0]            s_axis_tuser,   // [0] frame_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
	output logic [0:0]            m_axis_tuser,   // [0] byte_valid
	output logic                  m_axis_tlast    // frame_end
);

	logic accept;
	logic push, pop, full, head_valid;
	cmd_t cmd, head;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	lp2sc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (s_axis_tdata[7:0]),
		.frame_length(s_axis_tdata[32:8]),
		.frame_start (s_axis_tuser[0]),
		.push        (push),
		.cmd         (cmd)
	);

	lp2sc_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	lp2sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser[0]),
		.m_tlast   (m_axis_tlast)
	);

endmodule
